// ===== src/rmf_pkg.sv =====
package rmf_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned WindowSize = 3;
  localparam int unsigned PixW       = 24;

  // configuration register indexes
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        run_last;
  } pix_out_t;

  // compare-exchange helpers for the median network
  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

endpackage

// ===== src/rmf_ram.sv =====
module rmf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/rmf_median.sv =====
// Pipelined median of nine for one 8-bit channel.
// Stage 1: sort each column of three. Stage 2: max of mins, med of meds,
// min of maxes. Output: median of those three (combinational after stage 2).
module rmf_median (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [71:0] win_i,
  output logic [7:0] med_o
);

  logic [7:0] v [9];
  logic [7:0] lo_q [3], mi_q [3], hi_q [3];
  logic [7:0] a_q, b_q, c_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v[i] = win_i[8*i +: 8];
    end
  end

  // column sorts
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= rmf_pkg::min8(rmf_pkg::min8(v[k], v[k+3]), v[k+6]);
        hi_q[k] <= rmf_pkg::max8(rmf_pkg::max8(v[k], v[k+3]), v[k+6]);
        mi_q[k] <= rmf_pkg::med3(v[k], v[k+3], v[k+6]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= rmf_pkg::max8(rmf_pkg::max8(lo_q[0], lo_q[1]), lo_q[2]);
      b_q <= rmf_pkg::med3(mi_q[0], mi_q[1], mi_q[2]);
      c_q <= rmf_pkg::min8(rmf_pkg::min8(hi_q[0], hi_q[1]), hi_q[2]);
    end
  end

  assign med_o = rmf_pkg::med3(a_q, b_q, c_q);

endmodule

// ===== src/rgb_median3x3_filter.sv =====
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid_i/in_stall_o | rmf_pkg::pix_in_t
// out     | out | out_valid_o/out_stall_i | rmf_pkg::pix_out_t
// cfg     | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
// One pixel per cycle in while not stalled; each pixel passes read (line RAMs),
// window, two median stages and then waits in a result register that walks the run
// of up to nine outputs, one per cycle unless stalled. A pixel with a longer run holds
// the input until its run is out. The pipeline advances as a whole when the
// result register is free or being emptied. Reset clears counters, valids and window.
module rgb_median3x3_filter #(
  parameter int unsigned MaxWidth  = rmf_pkg::MaxWidth,
  parameter int unsigned MaxHeight = rmf_pkg::MaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rmf_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rmf_pkg::pix_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmf_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned ColW  = $clog2(MaxWidth + 1);
  localparam int unsigned RowW  = $clog2(MaxHeight + 1);
  localparam int unsigned PixW  = rmf_pkg::PixW;

  // registers
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [ColW-1:0] w_eff, c_q;
  logic [RowW-1:0] h_eff, r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmf_pkg::RegWidth:  width_q  <= cfg_data_i[10:0];
        rmf_pkg::RegHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < 11'd3) w_eff = ColW'(3);
    else if (32'(width_q) > MaxWidth) w_eff = ColW'(MaxWidth);
    else w_eff = ColW'(width_q);
    if (height_q < 13'd3) h_eff = RowW'(3);
    else if (32'(height_q) > MaxHeight) h_eff = RowW'(MaxHeight);
    else h_eff = RowW'(height_q);
  end

  // pipeline control: s1 = RAM read, s2 = window/median stage 1, s3 = stage 2,
  // s4 = result register that emits the run
  logic adv, acc;
  logic v1_q, v2_q, v3_q, v4_q;
  logic run_busy;

  assign adv = !v4_q || (!out_stall_i && !run_busy);
  assign in_stall_o = !adv;
  assign acc = in_valid_i && adv;

  typedef struct packed {
    logic [RowW-1:0] r;
    logic [ColW-1:0] c;
    logic [AddrW-1:0] a;
    logic [PixW-1:0] pix;
  } tag_t;

  tag_t t1_q, t2_q, t3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else if (cfg_we_i) begin
      c_q <= '0;
      r_q <= '0;
    end else if (acc) begin
      if (c_q + ColW'(1) >= w_eff) begin
        c_q <= '0;
        r_q <= (r_q + RowW'(1) >= h_eff) ? '0 : r_q + RowW'(1);
      end else begin
        c_q <= c_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q <= '{r: r_q, c: c_q, a: c_q[AddrW-1:0], pix: in_data_i};
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  // line RAMs: read at accept, write back in s1 (same column, later cycle)
  logic [PixW-1:0] up_rd, mid_rd, up_s, mid_s, up_hold_q, mid_hold_q;
  logic rd_fresh_q;

  rmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(v1_q && adv), .waddr_i(t1_q.a), .wdata_i(mid_s),
    .re_i(acc), .raddr_i(c_q[AddrW-1:0]), .rdata_o(up_rd)
  );
  rmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(v1_q && adv), .waddr_i(t1_q.a), .wdata_i(t1_q.pix),
    .re_i(acc), .raddr_i(c_q[AddrW-1:0]), .rdata_o(mid_rd)
  );

  // read data is valid the cycle after accept; hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_fresh_q <= 1'b0;
    else rd_fresh_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (rd_fresh_q) begin
      up_hold_q  <= up_rd;
      mid_hold_q <= mid_rd;
    end
  end
  // same column written by the previous item only when width is 1: never (>=3)
  assign up_s  = rd_fresh_q ? up_rd : up_hold_q;
  assign mid_s = rd_fresh_q ? mid_rd : mid_hold_q;

  // window, row-major: entry m*3+n
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      win_d[m*3]   = win_q[m*3+1];
      win_d[m*3+1] = win_q[m*3+2];
    end
    win_d[2] = up_s;
    win_d[5] = mid_s;
    win_d[8] = t1_q.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (v1_q && adv) begin
      for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
    end
  end

  // medians: window flattened per channel
  logic [71:0] wr, wg, wb;
  logic [7:0] mr, mg, mb;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      wr[8*i +: 8] = win_d[i][23:16];
      wg[8*i +: 8] = win_d[i][15:8];
      wb[8*i +: 8] = win_d[i][7:0];
    end
  end

  // stage-1 registers load with s1 advance, so median out aligns with s3
  rmf_median u_med_r (.clk_i, .en_i(adv), .win_i(wr), .med_o(mr));
  rmf_median u_med_g (.clk_i, .en_i(adv), .win_i(wg), .med_o(mg));
  rmf_median u_med_b (.clk_i, .en_i(adv), .win_i(wb), .med_o(mb));

  // result register and run walker
  logic [7:0] or_q, og_q, ob_q;
  logic [RowW-1:0] rows_q [3];
  logic [ColW-1:0] cols_q [3];
  logic [1:0] nr_q, nc_q, ri_q, ci_q;
  logic [RowW-1:0] ir;
  logic [ColW-1:0] ic;
  logic emit3;
  logic last_one;

  assign ir = t3_q.r - RowW'(1);
  assign ic = t3_q.c - ColW'(1);
  assign emit3 = v3_q && (t3_q.r >= RowW'(2)) && (t3_q.c >= ColW'(2));
  assign last_one = (ri_q + 2'd1 == nr_q) && (ci_q + 2'd1 == nc_q);
  assign run_busy = !last_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      ri_q <= '0;
      ci_q <= '0;
    end else if (adv) begin
      v4_q <= emit3;
      ri_q <= '0;
      ci_q <= '0;
    end else if (!out_stall_i) begin
      if (ci_q + 2'd1 == nc_q) begin
        ci_q <= '0;
        ri_q <= ri_q + 2'd1;
      end else begin
        ci_q <= ci_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      or_q <= mr;
      og_q <= mg;
      ob_q <= mb;
      if (ir == RowW'(1)) begin
        rows_q[0] <= '0;
        rows_q[1] <= ir;
        rows_q[2] <= h_eff - RowW'(1);
        nr_q <= (ir == h_eff - RowW'(2)) ? 2'd3 : 2'd2;
      end else begin
        rows_q[0] <= ir;
        rows_q[1] <= h_eff - RowW'(1);
        rows_q[2] <= h_eff - RowW'(1);
        nr_q <= (ir == h_eff - RowW'(2)) ? 2'd2 : 2'd1;
      end
      if (ic == ColW'(1)) begin
        cols_q[0] <= '0;
        cols_q[1] <= ic;
        cols_q[2] <= w_eff - ColW'(1);
        nc_q <= (ic == w_eff - ColW'(2)) ? 2'd3 : 2'd2;
      end else begin
        cols_q[0] <= ic;
        cols_q[1] <= w_eff - ColW'(1);
        cols_q[2] <= w_eff - ColW'(1);
        nc_q <= (ic == w_eff - ColW'(2)) ? 2'd2 : 2'd1;
      end
    end
  end

  assign out_valid_o = v4_q;
  always_comb begin
    out_data_o.out_row   = 12'(rows_q[ri_q]);
    out_data_o.out_col   = 10'(cols_q[ci_q]);
    out_data_o.out_red   = or_q;
    out_data_o.out_green = og_q;
    out_data_o.out_blue  = ob_q;
    out_data_o.run_last  = last_one;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rmf_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pix_out_t          out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegWidth;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Settle     = 20;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          idling_on = 1'b1;

  rgb_median3x3_filter uut (.*);

  always #1 clk_i = ~clk_i;

  // Median filter predictor with its own line stores, window and counters
  class median_scoreboard;
    logic [23:0]  upper_line[MaxWidth];
    logic [23:0]  middle_line[MaxWidth];
    logic [23:0]  win[9];
    int unsigned  row_cnt, col_cnt;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    pix_out_t     pending[$];

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      width_reg = 11'd640;
      height_reg = 13'd480;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegWidth) width_reg = val[10:0];
      else height_reg = val;
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    function logic [7:0] median_of(int unsigned shift);
      logic [7:0] v[9];
      logic [7:0] t;
      int j;
      for (int i = 0; i < 9; i++) begin
        t = win[i][shift +: 8];
        j = i;
        while (j > 0 && v[j-1] > t) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = t;
      end
      return v[4];
    endfunction

    // one accepted pixel request: update state, queue the run it causes
    function void note_request(pix_in_t p);
      int unsigned w, h, ir, ic, nr, nc;
      int unsigned rows[3], cols[3];
      logic [23:0] up, mid, pix;
      pix_out_t o;
      w = (width_reg < 3) ? 3 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
      h = (height_reg < 3) ? 3 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
      pix = {p.in_red, p.in_green, p.in_blue};
      up = upper_line[col_cnt];
      mid = middle_line[col_cnt];
      upper_line[col_cnt] = mid;
      middle_line[col_cnt] = pix;
      for (int m = 0; m < 3; m++) begin
        win[m*3] = win[m*3+1];
        win[m*3+1] = win[m*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = pix;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        ir = row_cnt - 1;
        ic = col_cnt - 1;
        nr = 0;
        nc = 0;
        if (ir == 1) rows[nr++] = 0;
        rows[nr++] = ir;
        if (ir == h - 2) rows[nr++] = h - 1;
        if (ic == 1) cols[nc++] = 0;
        cols[nc++] = ic;
        if (ic == w - 2) cols[nc++] = w - 1;
        o.out_red = median_of(16);
        o.out_green = median_of(8);
        o.out_blue = median_of(0);
        for (int m = 0; m < nr; m++) begin
          for (int n = 0; n < nc; n++) begin
            o.out_row = rows[m][11:0];
            o.out_col = cols[n][9:0];
            o.run_last = (m == nr - 1) && (n == nc - 1);
            pending.push_back(o);
          end
        end
      end
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    // returns an empty string when the result matches the oldest expectation
    function string check_result(pix_out_t got);
      pix_out_t e;
      string s;
      if (pending.size() == 0) return $sformatf("result with nothing expected: %p", got);
      e = pending.pop_front();
      s = "";
      if (got.out_row !== e.out_row)
        s = {s, $sformatf(" row %0d/%0d", got.out_row, e.out_row)};
      if (got.out_col !== e.out_col)
        s = {s, $sformatf(" col %0d/%0d", got.out_col, e.out_col)};
      if (got.out_red !== e.out_red)
        s = {s, $sformatf(" red %0h/%0h", got.out_red, e.out_red)};
      if (got.out_green !== e.out_green)
        s = {s, $sformatf(" green %0h/%0h", got.out_green, e.out_green)};
      if (got.out_blue !== e.out_blue)
        s = {s, $sformatf(" blue %0h/%0h", got.out_blue, e.out_blue)};
      if (got.run_last !== e.run_last)
        s = {s, $sformatf(" last %0b/%0b", got.run_last, e.run_last)};
      if (s != "") s = {"mismatch (got/exp) at", s, $sformatf(" for r%0d c%0d", e.out_row, e.out_col)};
      return s;
    endfunction
  endclass

  median_scoreboard sb = new();

  task automatic report(string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // watch both handshakes; values are the ones before this edge
  always @(posedge clk_i) begin
    string msg;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rgb_median3x3_filter");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        msg = sb.check_result(out_data_o);
        if (msg != "") report(msg);
      end
    end
  end

  // receiver stalls in random bursts while idling is on
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_pixel(pix_in_t p);
    if (idling_on && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain the outputs and let pixels with no result leave the pipeline
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_idle();
    write_reg(RegWidth, w[CfgDataW-1:0]);
    write_reg(RegHeight, h[CfgDataW-1:0]);
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = pix_in_t'(24'($urandom));
    // extremes now and then so medians land on 0 and 255
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      2: p.in_green = 8'hff;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int unsigned sent, w, h, n;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame: one window covers all nine pixels
    set_frame(3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? pix_in_t'(24'hff00ff)
                         : pix_in_t'(24'(24'h00ff00 ^ (i * 24'h010101))));
    // width above range clamps to the maximum, height below range to three
    set_frame(2047, 0);
    for (int i = 0; i < 4; i++) send_pixel('1);
    // width below range, height above range
    set_frame(0, 8191);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? pix_in_t'('1) : pix_in_t'('0));

    // random frames, mostly whole ones, sometimes cut short
    while (sent < 220) begin
      case ($urandom_range(0, 5))
        0: begin w = 3; h = 3; end
        1: begin w = $urandom_range(0, 2); h = $urandom_range(3, 5); end
        2: begin w = 1024; h = 3; end
        default: begin w = $urandom_range(3, 9); h = $urandom_range(3, 7); end
      endcase
      set_frame(w, h);
      if (w < 3) w = 3;
      if (w == 1024) n = $urandom_range(5, 30);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, w * h);
      else n = w * h * $urandom_range(1, 2);
      for (int i = 0; i < n && sent < 220; i++) begin
        if (sent > 180) idling_on = 1'b0;
        send_pixel(rand_pixel());
        sent++;
      end
    end

    wait_idle();
    if (errors == 0) $display("PASS rgb_median3x3_filter");
    else $display("FAIL rgb_median3x3_filter");
    $finish;
  end

endmodule
